// ----- sv/ascii_frame_crc_checker_top_macros.svh -----
// assertion helpers for the frame checker top level
`ifndef ASCII_FRAME_CRC_CHECKER_TOP_MACROS_SVH
`define ASCII_FRAME_CRC_CHECKER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define AFCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame checker assertion failed");
`define AFCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame checker assertion failed");
`else
`define AFCC_ASSERT_NOW(lbl, ante, cons)
`define AFCC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- sv/afcc_pkg.sv -----
package afcc_pkg;

  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] HEX_BAD_VALUE = 16'hFFFF;
  localparam logic [7:0]  CHAR_AT       = 8'h40;
  localparam logic [7:0]  CHAR_LF       = 8'h0A;
  localparam logic [7:0]  CHAR_CR       = 8'h0D;
  localparam logic [7:0]  CHAR_STAR     = 8'h2A;
  localparam logic [7:0]  LIMIT_RESET   = 8'd224;
  localparam logic [2:0]  HEX_LEN       = 3'd4;
  localparam logic [2:0]  STAR_CNT_MAX  = 3'd5;

  typedef enum logic [1:0] {
    STATUS_GOOD     = 2'd0,
    STATUS_FORMAT   = 2'd1,
    STATUS_MISMATCH = 2'd2
  } status_t;

  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [7:0]  body_len;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
  } verdict_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h61 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ----- sv/afcc_crc_byte.sv -----
module afcc_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);
  import afcc_pkg::*;

  logic [15:0] c;

  // msb-first crc16 over one byte, eight shift steps
  always_comb begin
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ----- sv/afcc_parser.sv -----
module afcc_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         data,
  input  logic [7:0]         max_body_len,
  output afcc_pkg::verdict_t verdict
);
  import afcc_pkg::*;

  logic        in_frame, in_frame_next;
  logic [7:0]  stored_count, stored_count_next;
  logic        overflowed, overflowed_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] crc_before_star, crc_before_star_next;
  logic [7:0]  star_position, star_position_next;
  logic        star_seen, star_seen_next;
  logic [2:0]  chars_after_star, chars_after_star_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic        hex_bad, hex_bad_next;

  logic [15:0] crc_added;
  logic        ok_form;
  logic [15:0] rx_crc;
  hex_t        hex;

  afcc_crc_byte u_crc (
    .crc_in  (running_crc),
    .data    (data),
    .crc_out (crc_added)
  );

  assign hex     = hex_digit(data);
  assign ok_form = !overflowed && star_seen && (star_position != 8'd0) &&
                   (chars_after_star == HEX_LEN);
  assign rx_crc  = hex_bad ? HEX_BAD_VALUE : hex_accum;

  always_comb begin
    in_frame_next         = in_frame;
    stored_count_next     = stored_count;
    overflowed_next       = overflowed;
    running_crc_next      = running_crc;
    crc_before_star_next  = crc_before_star;
    star_position_next    = star_position;
    star_seen_next        = star_seen;
    chars_after_star_next = chars_after_star;
    hex_accum_next        = hex_accum;
    hex_bad_next          = hex_bad;
    verdict               = '0;

    if (step) begin
      if (!in_frame || data == CHAR_AT) begin
        if (data == CHAR_AT) begin
          in_frame_next         = 1'b1;
          stored_count_next     = 8'd0;
          overflowed_next       = 1'b0;
          running_crc_next      = CRC_INIT;
          crc_before_star_next  = CRC_INIT;
          star_position_next    = 8'd0;
          star_seen_next        = 1'b0;
          chars_after_star_next = 3'd0;
          hex_accum_next        = 16'd0;
          hex_bad_next          = 1'b0;
        end
      end else if (data == CHAR_LF) begin
        in_frame_next = 1'b0;
        if (overflowed || stored_count != 8'd0) begin
          verdict.valid = 1'b1;
          if (!ok_form) begin
            verdict.status = STATUS_FORMAT;
          end else begin
            verdict.status       = (crc_before_star == rx_crc) ? STATUS_GOOD
                                                                : STATUS_MISMATCH;
            verdict.body_len     = star_position;
            verdict.computed_crc = crc_before_star;
            verdict.received_crc = rx_crc;
          end
        end
      end else if (data == CHAR_CR) begin
        // dropped
      end else if (stored_count >= max_body_len) begin
        overflowed_next = 1'b1;
      end else begin
        if (data == CHAR_STAR) begin
          crc_before_star_next  = running_crc;
          star_position_next    = stored_count;
          star_seen_next        = 1'b1;
          chars_after_star_next = 3'd0;
          hex_accum_next        = 16'd0;
          hex_bad_next          = 1'b0;
        end else if (star_seen) begin
          if (chars_after_star < HEX_LEN) begin
            if (!hex.ok) begin
              hex_bad_next = 1'b1;
            end else begin
              hex_accum_next = {hex_accum[11:0], hex.value};
            end
          end
          if (chars_after_star < STAR_CNT_MAX) begin
            chars_after_star_next = chars_after_star + 3'd1;
          end
        end
        running_crc_next  = crc_added;
        stored_count_next = stored_count + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame         <= 1'b0;
      stored_count     <= 8'd0;
      overflowed       <= 1'b0;
      running_crc      <= CRC_INIT;
      crc_before_star  <= CRC_INIT;
      star_position    <= 8'd0;
      star_seen        <= 1'b0;
      chars_after_star <= 3'd0;
      hex_accum        <= 16'd0;
      hex_bad          <= 1'b0;
    end else begin
      in_frame         <= in_frame_next;
      stored_count     <= stored_count_next;
      overflowed       <= overflowed_next;
      running_crc      <= running_crc_next;
      crc_before_star  <= crc_before_star_next;
      star_position    <= star_position_next;
      star_seen        <= star_seen_next;
      chars_after_star <= chars_after_star_next;
      hex_accum        <= hex_accum_next;
      hex_bad          <= hex_bad_next;
    end
  end

endmodule

// ----- sv/ascii_frame_crc_checker_top.sv -----
// ascii frame crc checker
// rx channel: rx_byte with rx_valid / rx_stall, one received byte per transaction.
// res channel: status, body_len, computed_crc, received_crc with res_valid /
// res_stall, one transaction per non-empty frame, given at the line feed.
// config: cfg_wr_en / cfg_wr_data write max_body_len; only while the block is idle, a rule the block does not enforce.
// a byte is registered in the input register at acceptance and parsed as it leaves it; its
// verdict is then registered in the result register and shows on res_valid from there.
// throughput: one byte per cycle while no result is stalled; the byte-wide crc update and the framing
// decode both sit between the input register and the state/result registers.
// a stalled result is held in the result register; while it waits, a byte in
// the input register waits too and rx_stall is high, so the sender holds its
// transaction until res_stall drops.
// reset: frame hunting restarts, no result pending, max_body_len is 224.
`include "ascii_frame_crc_checker_top_macros.svh"
module ascii_frame_crc_checker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  status,
  output logic [7:0]  body_len,
  output logic [15:0] computed_crc,
  output logic [15:0] received_crc
);
  import afcc_pkg::*;

  logic [7:0] max_body_len;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_advance;
  logic       rx_accept;
  verdict_t   verdict;
  verdict_t   res;

  assign s1_advance = s1_valid && (!res_valid || !res_stall);
  assign rx_stall   = s1_valid && !s1_advance;
  assign rx_accept  = rx_valid && !rx_stall;

  afcc_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_advance),
    .data         (s1_byte),
    .max_body_len (max_body_len),
    .verdict      (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_len <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      max_body_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_accept) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_advance && verdict.valid) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && verdict.valid) begin
      res <= verdict;
    end
  end

  assign status       = res.status;
  assign body_len     = res.body_len;
  assign computed_crc = res.computed_crc;
  assign received_crc = res.received_crc;

  `AFCC_ASSERT_NOW(a_stall_needs_byte, rx_stall, s1_valid && res_valid && res_stall)
  `AFCC_ASSERT_NOW(a_format_zero, res_valid && status == STATUS_FORMAT, body_len == 8'd0 && computed_crc == 16'd0 && received_crc == 16'd0)
  `AFCC_ASSERT_NOW(a_good_match, res_valid && status == STATUS_GOOD, computed_crc == received_crc)
  `AFCC_ASSERT_NOW(a_mismatch_differs, res_valid && status == STATUS_MISMATCH, computed_crc != received_crc)

endmodule
